>>> rtl/rcws_pkg.sv
// Shared types and constants for the rolling checksum window search core.
// No dependencies; every other file in rtl/ imports this package.

package rcws_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int BYTE_W         = 8;
	localparam int SUM_W          = 32;
	localparam int CFG_LEN_W      = 7;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 32;

	localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RST = 7'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_LENGTH = 2'd0,
		REG_TARGET_SUM_A  = 2'd1,
		REG_TARGET_SUM_B  = 2'd2
	} reg_idx_t;

	// step: a word is taken this cycle; fresh: it opens a new section
	typedef struct packed {
		logic step;
		logic fresh;
	} step_ctrl_t;

endpackage

>>> rtl/rcws_cell.sv
// One byte cell of the window shift chain.
// Depends on rcws_pkg for the byte width.

module rcws_cell
	import rcws_pkg::*;
#(
	parameter int CELL_IDX = 0,
	parameter int IDX_W    = 6
) (
	input  logic              clk,
	input  logic              shift_en,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic [IDX_W-1:0]  tap_idx,
	output logic [BYTE_W-1:0] byte_out,
	output logic [BYTE_W-1:0] tap_out
);

	logic [BYTE_W-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= byte_in;
		end
	end

	assign byte_out = byte_q;
	// drive the byte onto the tap bus only when this cell is the oldest one in use
	assign tap_out  = (tap_idx == IDX_W'(CELL_IDX)) ? byte_q : '0;

endmodule

>>> rtl/rcws_sum_unit.sv
// Rolling sums A and B, fill count and byte position of the current section.
// Depends on rcws_pkg.

module rcws_sum_unit
	import rcws_pkg::*;
#(
	parameter int LEN_W = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  step_ctrl_t        ctrl,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [BYTE_W-1:0] leaving,
	input  logic [LEN_W-1:0]  eff_len,
	output logic [SUM_W-1:0]  sum_a,
	output logic [SUM_W-1:0]  sum_b,
	output logic [LEN_W-1:0]  fill,
	output logic [SUM_W-1:0]  next_pos
);

	logic [SUM_W-1:0]        sum_a_q, sum_b_q, pos_q;
	logic [LEN_W-1:0]        fill_q;
	logic [SUM_W-1:0]        a_base, b_base, pos_base, a_new, b_new, out_term;
	logic [LEN_W-1:0]        fill_base;
	logic [LEN_W+BYTE_W-1:0] prod;
	logic                    full;

	always_comb begin
		a_base    = ctrl.fresh ? '0 : sum_a_q;
		b_base    = ctrl.fresh ? '0 : sum_b_q;
		pos_base  = ctrl.fresh ? '0 : pos_q;
		fill_base = ctrl.fresh ? '0 : fill_q;
		full      = (fill_base >= eff_len);
		prod      = eff_len * leaving;
		out_term  = full ? SUM_W'(leaving) : '0;
		a_new     = a_base + SUM_W'(data_byte) - out_term;
		b_new     = b_base + a_new - (full ? SUM_W'(prod) : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			pos_q   <= '0;
			fill_q  <= '0;
		end else if (ctrl.step) begin
			sum_a_q <= a_new;
			sum_b_q <= b_new;
			pos_q   <= pos_base + SUM_W'(1);
			fill_q  <= full ? fill_base : fill_base + LEN_W'(1);
		end
	end

	assign sum_a    = sum_a_q;
	assign sum_b    = sum_b_q;
	assign fill     = fill_q;
	assign next_pos = pos_q;

endmodule

>>> rtl/rolling_checksum_window_search_core.sv
// Top level of the rolling checksum window search: config registers, the
// byte cell chain, the sum unit and the compare/result stage. Uses rcws_pkg,
// rcws_cell and rcws_sum_unit.
//
// Usage:
//   Input channel (byte_valid/byte_ready) carries one word per byte of a
//   section: data_byte plus last_byte, which closes the section. Output
//   channel (result_valid/result_ready) carries found and match_offset:
//   the first window whose sums equal the targets gives found = 1 and the
//   window's start offset; a section that ends unmatched gives found = 0.
//   Bytes after a match give nothing, the section's last byte included.
//   Config (cfg_we/cfg_index/cfg_wdata) writes window_length, target_sum_a
//   or target_sum_b, one per write; write only while the core is idle.
//   Throughput: one word per cycle while the output is not stalled. The sums
//   are registered at the edge that takes the word (one small multiply and
//   two adds off the cell chain tap), compared in the following cycle and
//   the result is registered when the compare stage advances.
//   Reset clears the sums, counters and pipeline and loads window_length 16
//   and zero targets; the byte cells are not cleared, the fill count guards
//   them. When the receiver stalls, one result waits in the output register
//   and one word in the compare stage; further words are held off.

module rolling_checksum_window_search_core
	import rcws_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic                  last_byte,
	output logic                  result_valid,
	input  logic                  result_ready,
	output logic                  found,
	output logic [SUM_W-1:0]      match_offset,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int IDX_W = $clog2(MAX_WINDOW);
	localparam int CMP_W = (LEN_W > CFG_LEN_W) ? LEN_W : CFG_LEN_W;

	// config registers
	logic [CFG_LEN_W-1:0] window_length_q;
	logic [SUM_W-1:0]     target_a_q, target_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			target_a_q      <= '0;
			target_b_q      <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_WINDOW_LENGTH: window_length_q <= cfg_wdata[CFG_LEN_W-1:0];
				REG_TARGET_SUM_A:  target_a_q      <= cfg_wdata[SUM_W-1:0];
				REG_TARGET_SUM_B:  target_b_q      <= cfg_wdata[SUM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp the window length into 1..MAX_WINDOW
	logic [CMP_W-1:0] wl_ext;
	logic [LEN_W-1:0] eff_len;
	logic [IDX_W-1:0] tap_idx;

	always_comb begin
		wl_ext = CMP_W'(window_length_q);
		if (wl_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
			eff_len = LEN_W'(MAX_WINDOW);
		end else begin
			eff_len = LEN_W'(wl_ext);
		end
		tap_idx = IDX_W'(eff_len - LEN_W'(1));
	end

	// handshake and pipeline control
	logic accept, s1_adv, s1_fire, fresh_q;
	logic s1_valid_q, last_s1;

	assign s1_adv     = !result_valid || result_ready;
	assign byte_ready = !s1_valid_q || s1_adv;
	assign accept     = byte_valid && byte_ready;
	assign s1_fire    = s1_valid_q && s1_adv;

	// a word with last_byte set leaves the next word to open a new section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_q    <= 1'b1;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fresh_q <= last_byte;
			end
			if (byte_ready) begin
				s1_valid_q <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1 <= last_byte;
		end
	end

	// byte cell chain, newest byte in cell 0; shift on every word taken
	logic [BYTE_W-1:0] cell_byte [MAX_WINDOW];
	logic [BYTE_W-1:0] cell_tap  [MAX_WINDOW];
	logic [BYTE_W-1:0] leaving;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		rcws_cell #(
			.CELL_IDX(i),
			.IDX_W   (IDX_W)
		) u_cell (
			.clk     (clk),
			.shift_en(accept),
			.byte_in ((i == 0) ? data_byte : cell_byte[(i == 0) ? 0 : i - 1]),
			.tap_idx (tap_idx),
			.byte_out(cell_byte[i]),
			.tap_out (cell_tap[i])
		);
	end

	always_comb begin
		leaving = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			leaving = leaving | cell_tap[i];
		end
	end

	// rolling sums
	step_ctrl_t       ctrl;
	logic [SUM_W-1:0] sum_a, sum_b, next_pos;
	logic [LEN_W-1:0] fill;

	assign ctrl.step  = accept;
	assign ctrl.fresh = fresh_q;

	rcws_sum_unit #(
		.LEN_W(LEN_W)
	) u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.data_byte(data_byte),
		.leaving  (leaving),
		.eff_len  (eff_len),
		.sum_a    (sum_a),
		.sum_b    (sum_b),
		.fill     (fill),
		.next_pos (next_pos)
	);

	// compare stage: sums hold the state after the word in s1
	logic done_q, active, match, produce;

	assign active  = !done_q;
	assign match   = (fill >= eff_len) && (sum_a == target_a_q) && (sum_b == target_b_q);
	assign produce = active && (match || last_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (s1_fire) begin
				if (last_s1) begin
					done_q <= 1'b0;
				end else if (active && match) begin
					done_q <= 1'b1;
				end
			end
			if (s1_fire && produce) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// start offset is the word's position minus (length - 1)
	always_ff @(posedge clk) begin
		if (s1_fire && produce) begin
			found        <= match;
			match_offset <= match ? (next_pos - SUM_W'(eff_len)) : '0;
		end
	end

`ifndef ASSERT_OFF
	a_offset_zero_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !found) |-> (match_offset == '0))
		else $error("not-found result carries a non-zero offset");

	a_sums_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> ($stable(sum_a) && $stable(sum_b)))
		else $error("sums moved while the compare stage was stalled");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(fill <= LEN_W'(MAX_WINDOW)))
		else $error("fill count beyond window store depth");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> byte_ready)
		else $error("input held off with an empty compare stage");
`endif

endmodule
